// ===== rtl/wpa_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpa_pkg
// Shared types and constants for the windowed point average block.
// ----------------------------------------------------------------------------
package wpa_pkg;

    localparam int COORD_W = 20;
    localparam int SUM_W   = 26;   // coordinate plus growth for up to 64 slots
    localparam int CNT_W   = 6;
    localparam int LIM_W   = 19;
    localparam int REG_W   = 3;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic signed [SUM_W-1:0]   t_sum;

    localparam logic [REG_W-1:0] REG_LIM_X   = 3'd0;
    localparam logic [REG_W-1:0] REG_LIM_Y   = 3'd1;
    localparam logic [REG_W-1:0] REG_LIM_Z   = 3'd2;
    localparam logic [REG_W-1:0] REG_MIN_CNT = 3'd3;
    localparam logic [REG_W-1:0] REG_SHIFT_X = 3'd4;
    localparam logic [REG_W-1:0] REG_DEFAULT = 3'd5;

    typedef enum logic [2:0] {
        S_IDLE,
        S_SUM1,
        S_DIV1,
        S_MARK,
        S_SUM3,
        S_DIV3,
        S_OUT
    } t_state;

    typedef struct packed {
        logic             start;
        logic [CNT_W-1:0] divisor;
    } t_div_req;

endpackage
`default_nettype wire

// ===== rtl/wpa_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpa_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module wpa_ram #(
    parameter int WIDTH = 60,
    parameter int DEPTH = 6
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule
`default_nettype wire

// ===== rtl/wpa_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// wpa_div
// Three-lane restoring divider, one quotient bit per cycle, truncating
// toward zero. All lanes share one unsigned divisor.
// ----------------------------------------------------------------------------
module wpa_div (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire wpa_pkg::t_div_req i_req,
    input  wire wpa_pkg::t_sum     i_num [3],
    output logic                   o_done,
    output wpa_pkg::t_coord        o_quot [3]
);

    localparam int SW = wpa_pkg::SUM_W;
    localparam int CW = wpa_pkg::CNT_W;
    localparam int NW = $clog2(SW + 1);

    logic          r_busy;
    logic [NW-1:0] r_cnt;
    logic [CW-1:0] r_d;
    logic [CW-1:0] r_rem [3];
    logic [SW-1:0] r_q   [3];
    logic          r_neg [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
            o_done <= 1'b0;
        end else begin
            o_done <= 1'b0;
            if (i_req.start) begin
                r_busy <= 1'b1;
                r_cnt  <= NW'(SW);
                r_d    <= i_req.divisor;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == NW'(1)) begin
                    r_busy <= 1'b0;
                    o_done <= 1'b1;
                end
            end
        end
    end

    for (genvar g = 0; g < 3; g++) begin : g_lane
        logic [CW:0] w_sh;
        logic        w_ge;
        assign w_sh = {r_rem[g], r_q[g][SW-1]};
        assign w_ge = (w_sh >= {1'b0, r_d});

        always_ff @(posedge i_clk) begin
            if (i_req.start) begin
                r_rem[g] <= '0;
                r_neg[g] <= i_num[g][SW-1];
                r_q[g]   <= i_num[g][SW-1] ? SW'(-i_num[g]) : SW'(i_num[g]);
            end else if (r_busy) begin
                r_rem[g] <= w_ge ? CW'(w_sh - {1'b0, r_d}) : w_sh[CW-1:0];
                r_q[g]   <= {r_q[g][SW-2:0], w_ge};
            end
        end

        assign o_quot[g] = r_neg[g] ? -r_q[g][wpa_pkg::COORD_W-1:0]
                                    :  r_q[g][wpa_pkg::COORD_W-1:0];
    end

endmodule
`default_nettype wire

// ===== rtl/windowed_point_average_outlier_reject.sv =====
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// windowed_point_average_outlier_reject
// 3D point ring history with mean, inlier marking and inlier mean.
// ----------------------------------------------------------------------------
// Sequence: clear and warm-up samples go straight to the output register;
//   filtered samples first pass three sequential history sweeps through the
//   slot RAM read port and two 26-bit bit-serial divisions, each launched by
//   a start strobe and ended by a done strobe.
// Flow: one transaction at a time; the next is taken once the result is
//   parked in the output register.
// Reset: synchronous active low; history empty, not ready, registers at defaults.
// ----------------------------------------------------------------------------
module windowed_point_average_outlier_reject #(
    parameter int HISTORY_DEPTH = 6
) (
    input  wire logic         i_clk,
    input  wire logic         i_rst_n,
    // x[19:0], y[39:20], z[59:40], point_valid[60], zero pad
    input  wire logic [63:0]  s_tdata,
    input  wire logic         s_tuser,    // command: 0 store, 1 clear
    input  wire logic         s_tvalid,
    output logic              s_tready,
    // avg_x[20:0] avg_y[40:21] avg_z[60:41] cur_x[81:61] cur_y[101:82]
    // cur_z[121:102] inlier_count[127:122] stable[128], zero pad
    output logic [135:0]      m_tdata,
    output logic              m_tvalid,
    input  wire logic         m_tready,
    input  wire logic         psel,
    input  wire logic         penable,
    input  wire logic         pwrite,
    input  wire logic [4:0]   paddr,
    input  wire logic [31:0]  pwdata,
    output logic [31:0]       prdata,
    output logic              pready
);

    localparam int D  = HISTORY_DEPTH;
    localparam int AW = $clog2(D);
    localparam int IW = $clog2(D + 1);
    localparam int CW = wpa_pkg::CNT_W;
    localparam int XW = wpa_pkg::COORD_W;
    localparam int SW = wpa_pkg::SUM_W;
    localparam int LW = wpa_pkg::LIM_W;

    // ---------------- configuration registers ----------------
    logic [LW-1:0]   r_lim_x, r_lim_y, r_lim_z;
    logic [CW-1:0]   r_min_cnt;
    wpa_pkg::t_coord r_shift_x, r_default;
    logic [wpa_pkg::REG_W-1:0] w_reg;

    assign pready = 1'b1;
    assign w_reg  = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_lim_x   <= LW'(4800);
            r_lim_y   <= LW'(1600);
            r_lim_z   <= LW'(320);
            r_min_cnt <= CW'(2);
            r_shift_x <= '0;
            r_default <= '0;
        end else if (psel && penable && pwrite) begin
            case (w_reg)
                wpa_pkg::REG_LIM_X:   r_lim_x   <= pwdata[LW-1:0];
                wpa_pkg::REG_LIM_Y:   r_lim_y   <= pwdata[LW-1:0];
                wpa_pkg::REG_LIM_Z:   r_lim_z   <= pwdata[LW-1:0];
                wpa_pkg::REG_MIN_CNT: r_min_cnt <= pwdata[CW-1:0];
                wpa_pkg::REG_SHIFT_X: r_shift_x <= pwdata[XW-1:0];
                wpa_pkg::REG_DEFAULT: r_default <= pwdata[XW-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (w_reg)
            wpa_pkg::REG_LIM_X:   prdata = {13'd0, r_lim_x};
            wpa_pkg::REG_LIM_Y:   prdata = {13'd0, r_lim_y};
            wpa_pkg::REG_LIM_Z:   prdata = {13'd0, r_lim_z};
            wpa_pkg::REG_MIN_CNT: prdata = {26'd0, r_min_cnt};
            wpa_pkg::REG_SHIFT_X: prdata = {12'd0, r_shift_x};
            wpa_pkg::REG_DEFAULT: prdata = {12'd0, r_default};
            default:              prdata = '0;
        endcase
    end

    // ---------------- sequencer state ----------------
    wpa_pkg::t_state r_state, n_state;
    logic [IW-1:0]   r_wi;          // 0..D, D means wrap pending
    logic            r_ready;
    logic [D-1:0]    r_valid;       // slot valid bits
    logic [D-1:0]    r_inl;         // slot inlier marks
    wpa_pkg::t_coord r_mean [3];
    logic [CW-1:0]   r_inl_cnt;
    wpa_pkg::t_coord r_cur_x, r_cur_y, r_cur_z;
    logic [IW-1:0]   r_idx;         // read issue index of the sweep
    logic [AW-1:0]   r_pidx;        // slot whose data is on the RAM output
    wpa_pkg::t_sum   r_sum [3];
    logic [CW-1:0]   r_n;
    logic            r_div_go;      // launch divider once the last slot is summed

    logic            w_acc, w_store, w_wrap, w_sweep, w_have, w_last, w_div_done;
    logic            w_out_load;
    logic [AW-1:0]   w_waddr;
    logic [3*XW-1:0] w_rdata;
    wpa_pkg::t_coord w_sx, w_sy, w_sz;
    wpa_pkg::t_coord w_quot [3];
    wpa_pkg::t_div_req w_div;

    assign s_tready = (r_state == wpa_pkg::S_IDLE);
    assign w_acc    = s_tvalid && s_tready;
    assign w_store  = w_acc && !s_tuser;
    assign w_wrap   = (r_wi == IW'(D));
    assign w_waddr  = w_wrap ? '0 : r_wi[AW-1:0];

    assign w_sweep  = (r_state == wpa_pkg::S_SUM1) || (r_state == wpa_pkg::S_MARK)
                   || (r_state == wpa_pkg::S_SUM3);
    assign w_have   = w_sweep && (r_idx != '0);
    assign w_last   = (r_idx == IW'(D));
    assign w_out_load = (r_state == wpa_pkg::S_OUT) && (!m_tvalid || m_tready);

    wpa_ram #(.WIDTH(3 * XW), .DEPTH(D)) u_slots (
        .i_clk   (i_clk),
        .i_we    (w_store),
        .i_waddr (w_waddr),
        .i_wdata ({s_tdata[59:40], s_tdata[39:20], s_tdata[19:0]}),
        .i_raddr (w_last ? '0 : r_idx[AW-1:0]),
        .o_rdata (w_rdata)
    );

    assign w_sx = w_rdata[XW-1:0];
    assign w_sy = w_rdata[2*XW-1:XW];
    assign w_sz = w_rdata[3*XW-1:2*XW];

    // the last slot lands in the sums at the sweep's final edge, so the
    // divider starts on the first divide cycle
    assign w_div.start   = r_div_go;
    assign w_div.divisor = r_n;

    wpa_div u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (w_div),
        .i_num   (r_sum),
        .o_done  (w_div_done),
        .o_quot  (w_quot)
    );

    // per-axis strict distance test against the first mean
    logic signed [XW:0] w_dx, w_dy, w_dz;
    logic        [XW:0] w_ax, w_ay, w_az;
    logic               w_is_inl;
    assign w_dx = {w_sx[XW-1], w_sx} - {r_mean[0][XW-1], r_mean[0]};
    assign w_dy = {w_sy[XW-1], w_sy} - {r_mean[1][XW-1], r_mean[1]};
    assign w_dz = {w_sz[XW-1], w_sz} - {r_mean[2][XW-1], r_mean[2]};
    assign w_ax = w_dx[XW] ? -w_dx : w_dx;
    assign w_ay = w_dy[XW] ? -w_dy : w_dy;
    assign w_az = w_dz[XW] ? -w_dz : w_dz;
    assign w_is_inl = (w_ax < {2'b00, r_lim_x}) && (w_ay < {2'b00, r_lim_y})
                   && (w_az < {2'b00, r_lim_z});

    always_comb begin
        n_state = r_state;
        case (r_state)
            wpa_pkg::S_IDLE: begin
                if (w_acc) begin
                    n_state = (w_store && (r_ready || w_wrap)) ? wpa_pkg::S_SUM1
                                                               : wpa_pkg::S_OUT;
                end
            end
            wpa_pkg::S_SUM1: if (w_last) n_state = wpa_pkg::S_DIV1;
            wpa_pkg::S_DIV1: if (w_div_done) n_state = wpa_pkg::S_MARK;
            wpa_pkg::S_MARK: if (w_last) n_state = wpa_pkg::S_SUM3;
            wpa_pkg::S_SUM3: if (w_last) n_state = wpa_pkg::S_DIV3;
            wpa_pkg::S_DIV3: if (w_div_done) n_state = wpa_pkg::S_OUT;
            wpa_pkg::S_OUT:  if (w_out_load) n_state = wpa_pkg::S_IDLE;
            default:         n_state = wpa_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= wpa_pkg::S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // history bookkeeping, sweeps and means
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wi      <= '0;
            r_ready   <= 1'b0;
            r_valid   <= '0;
            r_inl     <= '0;
            r_inl_cnt <= '0;
            r_idx     <= '0;
            r_div_go  <= 1'b0;
            for (int a = 0; a < 3; a++) r_mean[a] <= '0;
        end else begin
            r_div_go <= w_last && ((r_state == wpa_pkg::S_SUM1)
                                || (r_state == wpa_pkg::S_SUM3));

            if (w_acc) begin
                r_idx <= '0;
                r_n   <= '0;
                for (int a = 0; a < 3; a++) r_sum[a] <= '0;
                if (s_tuser) begin
                    // clear: slots go invalid; their stale contents are never used
                    r_ready <= 1'b0;
                    r_valid <= '0;
                    r_inl   <= '0;
                    r_cur_x <= r_default;
                    r_cur_y <= r_default;
                    r_cur_z <= r_default;
                end else begin
                    if (w_wrap) r_ready <= 1'b1;
                    r_wi <= IW'(w_waddr) + 1'b1;
                    r_valid[w_waddr] <= s_tdata[60];
                    r_cur_x <= s_tdata[19:0];
                    r_cur_y <= s_tdata[39:20];
                    r_cur_z <= s_tdata[59:40];
                end
            end

            if (w_sweep) begin
                r_idx  <= w_last ? '0 : r_idx + 1'b1;
                r_pidx <= r_idx[AW-1:0];
            end

            if (r_state == wpa_pkg::S_MARK && r_idx == '0) begin
                r_inl_cnt <= '0;
            end

            if (w_have) begin
                case (r_state)
                    wpa_pkg::S_MARK: begin
                        if (r_valid[r_pidx]) begin
                            r_inl[r_pidx] <= w_is_inl;
                            if (w_is_inl) r_inl_cnt <= r_inl_cnt + 1'b1;
                        end
                    end
                    default: begin
                        if (r_valid[r_pidx] &&
                            (r_state == wpa_pkg::S_SUM1 || r_inl[r_pidx])) begin
                            r_sum[0] <= r_sum[0] + SW'(w_sx);
                            r_sum[1] <= r_sum[1] + SW'(w_sy);
                            r_sum[2] <= r_sum[2] + SW'(w_sz);
                            r_n      <= r_n + 1'b1;
                        end
                    end
                endcase
            end

            if (r_state == wpa_pkg::S_MARK && w_last) begin
                r_n <= '0;
                for (int a = 0; a < 3; a++) r_sum[a] <= '0;
            end

            if (w_div_done) begin
                // empty average falls back to the default point
                for (int a = 0; a < 3; a++) begin
                    r_mean[a] <= (r_n == '0) ? r_default : w_quot[a];
                end
            end
        end
    end

    // output register: result parks here while the next transaction is taken
    logic signed [XW:0] w_avg_x, w_cx;
    assign w_avg_x = {r_mean[0][XW-1], r_mean[0]} + {r_shift_x[XW-1], r_shift_x};
    assign w_cx    = {r_cur_x[XW-1], r_cur_x} + {r_shift_x[XW-1], r_shift_x};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_tvalid <= 1'b0;
        end else if (w_out_load) begin
            m_tvalid <= 1'b1;
        end else if (m_tready) begin
            m_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_out_load) begin
            m_tdata <= {7'd0, r_ready && (r_inl_cnt > r_min_cnt), r_inl_cnt,
                        r_cur_z, r_cur_y, w_cx, r_mean[2], r_mean[1], w_avg_x};
        end
    end

    // ---------------- assertions ----------------
    a_wi_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_wi <= IW'(D))
        else $error("write index past history depth");

    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_inl_cnt <= CW'(D))
        else $error("inlier count above history depth");

    a_busy_after_acc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("second transaction taken while one is in flight");

    a_div_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div_done |-> (r_state == wpa_pkg::S_DIV1 || r_state == wpa_pkg::S_DIV3))
        else $error("divider finished outside a divide step");

endmodule
`default_nettype wire
